FILE: rtl/cmpb_pkg.sv
// shared types and constants for the color map pixel blend block
// no dependencies
`default_nettype none

package cmpb_pkg;

   localparam int unsigned LANES      = 4;
   localparam int unsigned LANE_W     = 8;
   localparam int unsigned PIXEL_W    = LANES * LANE_W;
   localparam int unsigned OPA_W      = 8;
   localparam int unsigned ACC_W      = 16;
   localparam int unsigned OPA_SHIFT  = 6;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned ALPHA_LANE = 3;

   localparam logic [LANE_W:0]      ALPHA_ONE       = 9'h100;
   localparam logic [LANE_W-1:0]    LANE_MAX        = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] REG_BLEND_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_MODE  = 2'd1;

   localparam logic MODE_OPACITY  = 1'b0;
   localparam logic MODE_ADDITIVE = 1'b1;

   typedef struct packed {
      logic [LANE_W-1:0] d;
      logic [OPA_W-1:0]  s;
      logic [LANE_W-1:0] c;
      logic              alpha_one;
      logic              mode;
   } lane_in_type;

endpackage

`default_nettype wire

FILE: rtl/cmpb_lane.sv
// one byte lane of the blend: operand setup, multiply, add, clamp
// four register stages; depends on cmpb_pkg
`default_nettype none

module cmpb_lane (
   input  wire logic                       clock,
   input  wire cmpb_pkg::lane_in_type      lane_in,
   output logic [cmpb_pkg::LANE_W-1:0]     lane_out
);
   import cmpb_pkg::*;

   // stage 1: operands
   logic [LANE_W-1:0] d1_ff;
   logic [OPA_W-1:0]  s1_ff;
   logic [LANE_W:0]   x1_ff, x1_in;
   logic [LANE_W:0]   c1_ff, c1_in;
   logic              m1_ff;

   // stage 2: products
   logic [LANE_W-1:0] d2_ff;
   logic [ACC_W-1:0]  p1_ff, p1_in;
   logic [ACC_W-1:0]  p2_ff, p2_in;
   logic              m2_ff;

   // stage 3: lane sum
   logic [ACC_W-1:0]  v3_ff, v3_in;

   // stage 4: clamped byte
   logic [LANE_W-1:0] r4_ff, r4_in;

   always_comb begin
      c1_in = lane_in.alpha_one ? ALPHA_ONE : {1'b0, lane_in.c};
      if (lane_in.mode == MODE_ADDITIVE) begin
         x1_in = {1'b0, lane_in.d};
      end else begin
         x1_in = {1'b0, lane_in.c} - {1'b0, lane_in.d};
      end
   end

   always_comb begin
      p1_in = ACC_W'($signed(x1_ff) * $signed({1'b0, s1_ff}));
      p2_in = ACC_W'(c1_ff * s1_ff);
   end

   always_comb begin
      if (m2_ff == MODE_ADDITIVE) begin
         v3_in = {{(ACC_W-LANE_W){1'b0}}, d2_ff} - (p1_ff >> OPA_SHIFT)
                 + (p2_ff >> OPA_SHIFT);
      end else begin
         v3_in = {{(ACC_W-LANE_W){1'b0}}, d2_ff}
                 + ACC_W'($signed(p1_ff) >>> OPA_SHIFT);
      end
   end

   always_comb begin
      if (v3_ff[ACC_W-1]) begin
         r4_in = '0;
      end else if (|v3_ff[ACC_W-2:LANE_W]) begin
         r4_in = LANE_MAX;
      end else begin
         r4_in = v3_ff[LANE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      d1_ff <= lane_in.d;
      s1_ff <= lane_in.s;
      x1_ff <= x1_in;
      c1_ff <= c1_in;
      m1_ff <= lane_in.mode;
      d2_ff <= d1_ff;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      m2_ff <= m1_ff;
      v3_ff <= v3_in;
      r4_ff <= r4_in;
   end

   assign lane_out = r4_ff;

endmodule

`default_nettype wire

FILE: rtl/color_map_pixel_blend.sv
// color map pixel blend top level: csr registers, valid pipeline, four lanes
// depends on cmpb_pkg and cmpb_lane
// a request's result strobe leaves the last of four register stages
// (operands, products, sum, clamp) together with its result pixel
// throughput: one request per cycle, busy stays low; the receiver cannot stall
// reset: synchronous, clears blend color, blend mode and the stage valid bits
`default_nettype none

module color_map_pixel_blend (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [cmpb_pkg::PIXEL_W-1:0]      req_dest_pixel,
   input  wire logic [cmpb_pkg::OPA_W-1:0]        req_opacity,
   input  wire logic                              req_last_in,
   output logic                                   rsp_valid,
   output logic [cmpb_pkg::PIXEL_W-1:0]           rsp_result_pixel,
   output logic                                   rsp_last_out,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cmpb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cmpb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cmpb_pkg::*;

   localparam int unsigned STAGES = 4;

   logic [PIXEL_W-1:0] color_ff;
   logic               mode_ff;
   logic [STAGES-1:0]  valid_ff, valid_in;
   logic [STAGES-1:0]  last_ff, last_in;
   logic               take;

   lane_in_type        lane_in  [LANES];
   logic [LANE_W-1:0]  lane_out [LANES];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign take      = start & ~busy;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
         mode_ff  <= MODE_OPACITY;
      end else if (csr_valid & csr_ready) begin
         unique case (csr_index)
            REG_BLEND_COLOR: color_ff <= csr_data[PIXEL_W-1:0];
            REG_BLEND_MODE:  mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // request valid and last flag pipeline
   assign valid_in = {valid_ff[STAGES-2:0], take};
   assign last_in  = {last_ff[STAGES-2:0], req_last_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      last_ff <= last_in;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      always_comb begin
         lane_in[i].d         = req_dest_pixel[i*LANE_W +: LANE_W];
         lane_in[i].s         = req_opacity;
         lane_in[i].c         = color_ff[i*LANE_W +: LANE_W];
         lane_in[i].alpha_one = (mode_ff == MODE_ADDITIVE) && (i == ALPHA_LANE);
         lane_in[i].mode      = mode_ff;
      end

      cmpb_lane u_lane (
         .clock    (clock),
         .lane_in  (lane_in[i]),
         .lane_out (lane_out[i])
      );

      assign rsp_result_pixel[i*LANE_W +: LANE_W] = lane_out[i];
   end

   assign rsp_valid    = valid_ff[STAGES-1];
   assign rsp_last_out = last_ff[STAGES-1];

endmodule

`default_nettype wire
